>>> rtl/swdh_pkg.sv
// ----------------------------------------------------------------------------
// swdh_pkg
// Shared types, sizes and helpers for the wave-drive stepper sequencer.
// ----------------------------------------------------------------------------
package swdh_pkg;

    localparam int NUM_COILS = 4;   // 2 .. 8
    localparam int POS_WIDTH = 16;  // 8 .. 32

    localparam int PHASE_W   = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;

    // Field widths of the stream items
    localparam int FUNC_W    = 2;
    localparam int TARGET_W  = 16;
    localparam int COIL_W    = 4;
    localparam int CURPOS_W  = 16;
    localparam int MODE_W    = 2;

    localparam int S_TDATA_W = 24;  // target(16) + detector(1), padded
    localparam int M_TDATA_W = 24;  // coils(4) + position(16) + mode(2), padded

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(NUM_COILS - 1);
    localparam logic [63:0]        POS_MAX64  = (64'd1 << POS_WIDTH) - 64'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 2'd0,
        MODE_CALIB  = 2'd1,
        MODE_MOVING = 2'd2
    } mode_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_MOVE  = 2'd1,
        FUNC_CALIB = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // One-hot coil enables, only the low COIL_W coils are visible
    function automatic logic [COIL_W-1:0] coil_bits(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] res;
        res = '0;
        for (int i = 0; i < COIL_W; i++)
        begin
            res[i] = (i < NUM_COILS) && (32'(phase) == i);
        end
        return res;
    endfunction

    // Saturate a requested target to the position range
    function automatic logic [POS_WIDTH-1:0] sat_target(input logic [TARGET_W-1:0] tgt);
        logic [63:0] t64;
        t64 = 64'(tgt);
        if (t64 > POS_MAX64)
        begin
            t64 = POS_MAX64;
        end
        return t64[POS_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/stepper_wave_drive_homing.sv
// ----------------------------------------------------------------------------
// stepper_wave_drive_homing
// Wave-drive stepper sequencer with homing: ticks, move and calibrate requests.
// ----------------------------------------------------------------------------
// The result item is registered and valid in the cycle after its input item is accepted.
// Throughput: 1 item per cycle while results are taken (m_tready); the state update is one
//   compare and increment between the state registers and the result register.
// Reset: asynchronous, active low; comes up calibrating, position and
//   destination zero, phase zero (coil 0 selected), no result pending.
// ----------------------------------------------------------------------------
module stepper_wave_drive_homing
    import swdh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] target_position, [16] detector_active
    input  logic [FUNC_W-1:0]    s_tuser,  // [1:0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [3:0] coil_drive, [19:4] current_position,
                                           // [21:20] mode
);

    mode_t                run_mode_reg,    run_mode_next;
    logic [POS_WIDTH-1:0] position_reg,    position_next;
    logic [POS_WIDTH-1:0] destination_reg, destination_next;
    logic [PHASE_W-1:0]   phase_reg,       phase_next;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg,    out_data_next;

    logic [TARGET_W-1:0]  in_target;
    logic                 in_detector;
    func_t                in_func;
    logic                 in_accept;
    logic [31:0]          pos_ext;
    logic [PHASE_W-1:0]   phase_fwd, phase_bwd;

    assign in_target   = s_tdata[TARGET_W-1:0];
    assign in_detector = s_tdata[TARGET_W];
    assign in_func     = func_t'(s_tuser);

    // Result register frees up when its item is taken this cycle
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign phase_fwd = (phase_reg == PHASE_LAST) ? '0 : phase_reg + PHASE_W'(1);
    assign phase_bwd = (phase_reg == '0) ? PHASE_LAST : phase_reg - PHASE_W'(1);

    always_comb
    begin
        run_mode_next    = run_mode_reg;
        position_next    = position_reg;
        destination_next = destination_reg;
        phase_next       = phase_reg;
        case (in_func)
            FUNC_TICK:
            begin
                if (run_mode_reg == MODE_CALIB)
                begin
                    if (in_detector)
                    begin
                        phase_next = phase_fwd;
                    end
                    else
                    begin
                        run_mode_next    = MODE_IDLE;
                        position_next    = '0;
                        destination_next = '0;
                    end
                end
                else if (run_mode_reg == MODE_MOVING)
                begin
                    if (position_reg > destination_reg)
                    begin
                        phase_next    = phase_bwd;
                        position_next = position_reg - POS_WIDTH'(1);
                    end
                    else if (position_reg < destination_reg)
                    begin
                        phase_next    = phase_fwd;
                        position_next = position_reg + POS_WIDTH'(1);
                    end
                    else
                    begin
                        run_mode_next = MODE_IDLE;
                    end
                end
            end
            FUNC_MOVE:
            begin
                if (run_mode_reg == MODE_IDLE)
                begin
                    destination_next = sat_target(in_target);
                    run_mode_next    = MODE_MOVING;
                end
            end
            FUNC_CALIB:
            begin
                if (run_mode_reg == MODE_IDLE)
                begin
                    run_mode_next = MODE_CALIB;
                end
            end
            default:
            begin
                run_mode_next = run_mode_reg;
            end
        endcase

        pos_ext       = 32'(position_next);
        out_data_next = '0;
        out_data_next[COIL_W-1:0]                  = coil_bits(phase_next);
        out_data_next[COIL_W +: CURPOS_W]          = pos_ext[CURPOS_W-1:0];
        out_data_next[COIL_W + CURPOS_W +: MODE_W] = run_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg    <= MODE_CALIB;
            position_reg    <= '0;
            destination_reg <= '0;
            phase_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                run_mode_reg    <= run_mode_next;
                position_reg    <= position_next;
                destination_reg <= destination_next;
                phase_reg       <= phase_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Position moves only while moving or on the calibration exit
    a_pos_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (position_reg != $past(position_reg)) |-> ($past(run_mode_reg) != MODE_IDLE))
        else $error("position changed while idle");

    // A tick while idle leaves the block idle
    a_idle_tick_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_func == FUNC_TICK && run_mode_reg == MODE_IDLE)
        |=> (run_mode_reg == MODE_IDLE))
        else $error("tick left idle mode");

    // A result appears only after an item was taken
    a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_accept))
        else $error("result without accepted item");

    // At most one coil on
    a_coil_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tdata[COIL_W-1:0]))
        else $error("more than one coil driven");

endmodule
